FILE: rtl/grt_pkg.sv
// ----------------------------------------------------------------------------
// grt_pkg: shared types and constants of the grid ray traversal block
// Register indices, tile flag layout, divider request/response structs.
// ----------------------------------------------------------------------------
package grt_pkg;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 8;

    localparam logic [CFG_IW-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] REG_TILE_SIZE   = 2'd2;

    localparam logic [7:0] GRID_WIDTH_RST  = 8'd100;
    localparam logic [6:0] GRID_HEIGHT_RST = 7'd40;
    localparam logic [7:0] TILE_SIZE_RST   = 8'd32;

    localparam int FLAG_SOLID      = 0;
    localparam int FLAG_ONE_WAY    = 1;
    localparam int FLAG_BACKGROUND = 2;
    localparam logic [2:0] FLAGS_OUTSIDE = 3'b001;

    localparam logic signed [15:0] UNIT_Q15 = 16'sd32767;
    localparam logic signed [15:0] NEG_UNIT_Q15 = -16'sd32767;

    localparam int DIV_NW = 41;
    localparam int DIV_DW = 25;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quotient;
        logic [DIV_DW-1:0] remainder;
    } div_res_t;

    function automatic logic tile_blocks(logic [2:0] flags, logic pass_up);
        return flags[FLAG_SOLID] && !flags[FLAG_BACKGROUND] &&
               !(pass_up && flags[FLAG_ONE_WAY]);
    endfunction

endpackage

FILE: rtl/grt_if.sv
// ----------------------------------------------------------------------------
// grt_if: request and result channels
// Valid/ready channels carrying the request and result payloads.
// ----------------------------------------------------------------------------
interface grt_req_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [6:0]         tile_col;
    logic [5:0]         tile_row;
    logic [2:0]         tile_flags;
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
    logic signed [23:0] end_x;
    logic signed [23:0] end_y;
    logic               pass_one_way_upward;

    modport source (output valid, operation, tile_col, tile_row, tile_flags,
                    start_x, start_y, end_x, end_y, pass_one_way_upward,
                    input ready);
    modport sink (input valid, operation, tile_col, tile_row, tile_flags,
                  start_x, start_y, end_x, end_y, pass_one_way_upward,
                  output ready);
endinterface

interface grt_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [16:0]        hit_t;
    logic signed [15:0] face_nx;
    logic signed [15:0] face_ny;

    modport source (output valid, hit, hit_t, face_nx, face_ny, input ready);
    modport sink (input valid, hit, hit_t, face_nx, face_ny, output ready);
endinterface

FILE: rtl/grid_ray_traversal_hit.sv
// ----------------------------------------------------------------------------
// grid_ray_traversal_hit: tile map ray query
// Write result: in the cycle after the request. Query: a cell setup of two
// divisions, then a walk step per cell crossed (S_WMB skipped on an axis-aligned
// ray), plus a division for t on a hit; a start inside a blocking tile, on a ray
// of nonzero length, costs an integer square root and two divisions. One request
// at a time. After reset the tile store is cleared, with no request taken.
// ----------------------------------------------------------------------------
module grid_ray_traversal_hit #(
    parameter int MAP_COLS   = 128,
    parameter int MAP_ROWS   = 64,
    parameter int STEP_LIMIT = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [grt_pkg::CFG_IW-1:0] cfg_index,
    input  logic [grt_pkg::CFG_DW-1:0] cfg_wdata,
    grt_req_if.sink                    req,
    grt_rsp_if.source                  rsp
);
    import grt_pkg::*;

    localparam int DEPTH = MAP_COLS * MAP_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CBW   = $clog2(MAP_COLS);
    localparam int RBW   = $clog2(MAP_ROWS);
    localparam int TW    = (STEP_LIMIT > 32768 ? $clog2(STEP_LIMIT) : 15) + 3;
    localparam int SW    = $clog2(STEP_LIMIT);

    typedef enum logic [19:0] {
        S_CLEAR = 20'h00001,
        S_IDLE  = 20'h00002,
        S_DIVX  = 20'h00004,
        S_DIVY  = 20'h00008,
        S_RDS   = 20'h00010,
        S_CHKS  = 20'h00020,
        S_SQA   = 20'h00040,
        S_SQB   = 20'h00080,
        S_SQC   = 20'h00100,
        S_SQM   = 20'h00200,
        S_SQT   = 20'h00400,
        S_NDX   = 20'h00800,
        S_NDY   = 20'h01000,
        S_WMA   = 20'h02000,
        S_WMB   = 20'h04000,
        S_WDEC  = 20'h08000,
        S_WRD   = 20'h10000,
        S_WCHK  = 20'h20000,
        S_TDIV  = 20'h40000,
        S_OUT   = 20'h80000
    } state_t;

    state_t state_reg, state_next;
    logic   div_wait_reg, div_wait_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [SW-1:0] step_reg, step_next;
    logic [7:0] gw_reg;
    logic [6:0] gh_reg;
    logic [7:0] ts_reg;

    logic signed [23:0]   ax_reg, ax_next, ay_reg, ay_next;
    logic signed [24:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic                 pass_reg, pass_next;
    logic signed [TW-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic [24:0]          numx_reg, numx_next, numy_reg, numy_next;
    logic                 xaxis_reg, xaxis_next;
    logic [49:0]          sq_reg, sq_next, cross_reg, cross_next, prod_reg;
    logic [24:0]          root_reg, root_next;
    logic [4:0]           idx_reg, idx_next;
    logic                 hit_reg, hit_next;
    logic [16:0]          t_reg, t_next;
    logic signed [15:0]   nx_reg, nx_next, ny_reg, ny_next;

    logic [2:0]    mem [DEPTH];
    logic [2:0]    rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa, rd_addr;
    logic [2:0]    mem_wd;

    logic [24:0] mul_a, mul_b;
    div_cmd_t    div_cmd;
    div_res_t    div_res;

    logic [7:0]  tsu;
    logic [15:0] span;
    logic [23:0] adx, ady;
    logic        dx_pos, dy_pos, dx_zero, dy_zero;
    logic        inb, blk;
    logic [24:0] trial;

    logic signed [23:0] cur_a;
    logic signed [24:0] cur_d;
    logic        cur_neg;
    logic [16:0] cur_m;
    logic [7:0]  cur_r8;
    logic [15:0] cur_rem;
    logic [24:0] cur_num;
    logic [TW-1:0] cur_t;
    logic [24:0] walk_num;
    logic [23:0] walk_ad;
    logic [15:0] nq;
    logic        xfirst;

    grt_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .cmd (div_cmd),
        .res (div_res)
    );

    assign tsu     = (ts_reg == 8'd0) ? 8'd1 : ts_reg;
    assign span    = {tsu, 8'd0};
    assign adx     = dx_reg[24] ? 24'(-dx_reg) : dx_reg[23:0];
    assign ady     = dy_reg[24] ? 24'(-dy_reg) : dy_reg[23:0];
    assign dx_zero = (dx_reg == '0);
    assign dy_zero = (dy_reg == '0);
    assign dx_pos  = !dx_reg[24] && !dx_zero;
    assign dy_pos  = !dy_reg[24] && !dy_zero;

    assign inb = !tx_reg[TW-1] && !ty_reg[TW-1] &&
                 (tx_reg[TW-2:0] < (TW-1)'(gw_reg)) &&
                 (tx_reg[TW-2:0] < (TW-1)'(MAP_COLS)) &&
                 (ty_reg[TW-2:0] < (TW-1)'(gh_reg)) &&
                 (ty_reg[TW-2:0] < (TW-1)'(MAP_ROWS));
    assign rd_addr = inb ? (AW'(ty_reg[RBW-1:0]) * AW'(MAP_COLS) + AW'(tx_reg[CBW-1:0]))
                         : '0;
    assign blk   = tile_blocks(inb ? rd_data_reg : FLAGS_OUTSIDE, pass_reg);
    assign trial = root_reg | (25'd1 << idx_reg);

    assign cur_a   = (state_reg == S_DIVY) ? ay_reg : ax_reg;
    assign cur_d   = (state_reg == S_DIVY) ? dy_reg : dx_reg;
    assign cur_neg = cur_a[23];
    assign cur_m   = cur_neg ? (17'd0 - {1'b1, cur_a[23:8]}) : {1'b0, cur_a[23:8]};
    assign cur_r8  = cur_neg ? (tsu - 8'd1 - div_res.remainder[7:0])
                             : div_res.remainder[7:0];
    assign cur_rem = {cur_r8, cur_a[7:0]};
    assign cur_t   = cur_neg ? (TW'(0) - TW'(div_res.quotient[16:0]))
                             : TW'(div_res.quotient[16:0]);
    assign cur_num = (!cur_d[24] && cur_d != '0) ? (25'(span) - 25'(cur_rem)) :
                     cur_d[24] ? 25'(cur_rem) : 25'd0;

    assign walk_num = xaxis_reg ? numx_reg : numy_reg;
    assign walk_ad  = xaxis_reg ? adx : ady;
    assign nq       = div_res.quotient[15:0];
    assign xfirst   = (adx != '0) && ((ady == '0) || (cross_reg < prod_reg));

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = (state_reg == S_OUT);
    assign rsp.hit       = hit_reg;
    assign rsp.hit_t     = t_reg;
    assign rsp.face_nx   = nx_reg;
    assign rsp.face_ny   = ny_reg;

    always_comb
    begin
        state_next    = state_reg;
        div_wait_next = div_wait_reg;
        clr_next      = clr_reg;
        step_next     = step_reg;
        ax_next = ax_reg;
        ay_next = ay_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        pass_next  = pass_reg;
        tx_next    = tx_reg;
        ty_next    = ty_reg;
        numx_next  = numx_reg;
        numy_next  = numy_reg;
        xaxis_next = xaxis_reg;
        sq_next    = sq_reg;
        cross_next = cross_reg;
        root_next  = root_reg;
        idx_next   = idx_reg;
        hit_next   = hit_reg;
        t_next     = t_reg;
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        mem_we  = 1'b0;
        mem_wa  = clr_reg;
        mem_wd  = '0;
        mul_a   = '0;
        mul_b   = '0;
        div_cmd = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    hit_next = 1'b0;
                    t_next   = '0;
                    nx_next  = '0;
                    ny_next  = '0;
                    if (!req.operation)
                    begin
                        mem_we = (int'(req.tile_col) < MAP_COLS) &&
                                 (int'(req.tile_row) < MAP_ROWS);
                        mem_wa = AW'(req.tile_row) * AW'(MAP_COLS) + AW'(req.tile_col);
                        mem_wd = req.tile_flags;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        ax_next = req.start_x;
                        ay_next = req.start_y;
                        dx_next = {req.end_x[23], req.end_x} - {req.start_x[23], req.start_x};
                        dy_next = {req.end_y[23], req.end_y} - {req.start_y[23], req.start_y};
                        pass_next = req.pass_one_way_upward && dy_next[24];
                        state_next = S_DIVX;
                    end
                end
            end
            S_DIVX, S_DIVY:
            begin
                div_cmd.start    = !div_wait_reg;
                div_cmd.dividend = DIV_NW'(cur_m) +
                                   (cur_neg ? (DIV_NW'(tsu) - DIV_NW'(1)) : DIV_NW'(0));
                div_cmd.divisor  = DIV_DW'(tsu);
                div_wait_next    = 1'b1;
                if (div_res.done)
                begin
                    div_wait_next = 1'b0;
                    if (state_reg == S_DIVX)
                    begin
                        tx_next    = cur_t;
                        numx_next  = cur_num;
                        state_next = S_DIVY;
                    end
                    else
                    begin
                        ty_next    = cur_t;
                        numy_next  = cur_num;
                        state_next = S_RDS;
                    end
                end
            end
            S_RDS:
                state_next = S_CHKS;
            S_CHKS:
            begin
                if (blk)
                begin
                    hit_next = 1'b1;
                    if (dx_zero && dy_zero)
                    begin
                        ny_next    = NEG_UNIT_Q15;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_SQA;
                end
                else
                begin
                    step_next  = '0;
                    state_next = S_WMA;
                end
            end
            S_SQA:
            begin
                mul_a = 25'(adx);
                mul_b = 25'(adx);
                state_next = S_SQB;
            end
            S_SQB:
            begin
                mul_a = 25'(ady);
                mul_b = 25'(ady);
                sq_next = prod_reg;
                state_next = S_SQC;
            end
            S_SQC:
            begin
                sq_next   = sq_reg + prod_reg;
                root_next = '0;
                idx_next  = 5'd24;
                state_next = S_SQM;
            end
            S_SQM:
            begin
                mul_a = trial;
                mul_b = trial;
                state_next = S_SQT;
            end
            S_SQT:
            begin
                if (prod_reg <= sq_reg)
                    root_next = trial;
                idx_next = idx_reg - 5'd1;
                state_next = (idx_reg == 5'd0) ? S_NDX : S_SQM;
            end
            S_NDX, S_NDY:
            begin
                div_cmd.start    = !div_wait_reg;
                div_cmd.dividend = ((state_reg == S_NDX) ?
                                    ((DIV_NW'(adx) << 15) - DIV_NW'(adx)) :
                                    ((DIV_NW'(ady) << 15) - DIV_NW'(ady))) +
                                   DIV_NW'(root_reg >> 1);
                div_cmd.divisor  = root_reg;
                div_wait_next    = 1'b1;
                if (div_res.done)
                begin
                    div_wait_next = 1'b0;
                    if (state_reg == S_NDX)
                    begin
                        nx_next    = dx_pos ? (16'sd0 - $signed(nq)) : $signed(nq);
                        state_next = S_NDY;
                    end
                    else
                    begin
                        ny_next    = dy_pos ? (16'sd0 - $signed(nq)) : $signed(nq);
                        state_next = S_OUT;
                    end
                end
            end
            S_WMA:
            begin
                mul_a = numx_reg;
                mul_b = 25'(ady);
                state_next = ((adx != '0) && (ady != '0)) ? S_WMB : S_WDEC;
            end
            S_WMB:
            begin
                mul_a = numy_reg;
                mul_b = 25'(adx);
                cross_next = prod_reg;
                state_next = S_WDEC;
            end
            S_WDEC:
            begin
                xaxis_next = xfirst;
                if (xfirst)
                begin
                    tx_next = tx_reg + (dx_reg[24] ? {TW{1'b1}} : TW'(1));
                    state_next = (numx_reg > 25'(adx)) ? S_OUT : S_WRD;
                end
                else
                begin
                    ty_next = ty_reg + (dy_reg[24] ? {TW{1'b1}} : TW'(1));
                    state_next = ((ady == '0) || (numy_reg > 25'(ady))) ? S_OUT : S_WRD;
                end
            end
            S_WRD:
                state_next = S_WCHK;
            S_WCHK:
            begin
                if (blk)
                begin
                    hit_next   = 1'b1;
                    state_next = S_TDIV;
                end
                else
                begin
                    if (xaxis_reg)
                        numx_next = numx_reg + 25'(span);
                    else
                        numy_next = numy_reg + 25'(span);
                    step_next  = step_reg + SW'(1);
                    state_next = (step_reg == SW'(STEP_LIMIT - 1)) ? S_OUT : S_WMA;
                end
            end
            S_TDIV:
            begin
                div_cmd.start    = !div_wait_reg;
                div_cmd.dividend = (DIV_NW'(walk_num) << 16) + DIV_NW'(walk_ad >> 1);
                div_cmd.divisor  = DIV_DW'(walk_ad);
                div_wait_next    = 1'b1;
                if (div_res.done)
                begin
                    div_wait_next = 1'b0;
                    t_next = div_res.quotient[16:0];
                    if (xaxis_reg)
                    begin
                        nx_next = dx_pos ? NEG_UNIT_Q15 : UNIT_Q15;
                        ny_next = '0;
                    end
                    else
                    begin
                        nx_next = '0;
                        ny_next = dy_pos ? NEG_UNIT_Q15 : UNIT_Q15;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (rsp.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            div_wait_reg <= 1'b0;
            clr_reg      <= '0;
            step_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            div_wait_reg <= div_wait_next;
            clr_reg      <= clr_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= GRID_WIDTH_RST;
            gh_reg <= GRID_HEIGHT_RST;
            ts_reg <= TILE_SIZE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  gw_reg <= cfg_wdata;
                REG_GRID_HEIGHT: gh_reg <= cfg_wdata[6:0];
                REG_TILE_SIZE:   ts_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        pass_reg  <= pass_next;
        tx_reg    <= tx_next;
        ty_reg    <= ty_next;
        numx_reg  <= numx_next;
        numy_reg  <= numy_next;
        xaxis_reg <= xaxis_next;
        sq_reg    <= sq_next;
        cross_reg <= cross_next;
        root_reg  <= root_next;
        idx_reg   <= idx_next;
        hit_reg   <= hit_next;
        t_reg     <= t_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        prod_reg  <= mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[rd_addr];
    end

endmodule

FILE: rtl/grt_div.sv
// ----------------------------------------------------------------------------
// grt_div: shared unsigned divider
// Restoring division, one quotient bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
module grt_div (
    input  logic              clk,
    input  logic              rst_n,
    input  grt_pkg::div_cmd_t cmd,
    output grt_pkg::div_res_t res
);
    import grt_pkg::*;

    localparam int CW = $clog2(DIV_NW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW:0]   rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [DIV_DW:0]   shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        shifted   = {rem_reg[DIV_DW-1:0], quo_reg[DIV_NW-1]};
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DIV_NW);
            quo_next  = cmd.dividend;
            rem_next  = '0;
            den_next  = cmd.divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                quo_next = {quo_reg[DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg[DIV_DW-1:0];

endmodule

FILE: rtl/grt_checker.sv
// ----------------------------------------------------------------------------
// grt_checker: port-level checks of the ray query block
// Result coding and request/result ordering seen at the top-level ports.
// ----------------------------------------------------------------------------
module grt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               rsp_hit,
    input logic [16:0]        rsp_hit_t,
    input logic signed [15:0] rsp_face_nx,
    input logic signed [15:0] rsp_face_ny
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !rsp_valid)
        else $error("request taken while a result waits");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_hit_t == 17'd0 && rsp_face_nx == 16'sd0 &&
                                  rsp_face_ny == 16'sd0)
        else $error("miss result not all zero");

    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_hit |-> rsp_hit_t <= 17'd65536)
        else $error("hit parameter beyond one");

    a_face_normal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_hit && rsp_hit_t != 17'd0 |->
            (rsp_face_nx == 16'sd0) != (rsp_face_ny == 16'sd0))
        else $error("face hit without an axis normal");

endmodule

bind grid_ray_traversal_hit grt_checker u_grt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_hit      (rsp.hit),
    .rsp_hit_t    (rsp.hit_t),
    .rsp_face_nx  (rsp.face_nx),
    .rsp_face_ny  (rsp.face_ny)
);

FILE: dv/tb_grid_ray_traversal_hit.sv
// ----------------------------------------------------------------------------
// tb_grid_ray_traversal_hit: self-checking bench for the tile map ray query
// Loads tile flags and fires ray queries through the request channel under
// random idling on both sides. Each accepted request is predicted with an
// exact integer grid walk, and each result is compared field by field against
// the oldest expected result. The grid registers are swept through several
// settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_grid_ray_traversal_hit;
    import grt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  MAP_COLS   = 128;
    localparam int  MAP_ROWS   = 64;
    localparam int  STEP_LIMIT = 4096;
    localparam int  STALL_LIMIT = 60000;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam logic [2:0] TILE_WALL     = 3'b1 << FLAG_SOLID;
    localparam logic [2:0] TILE_ONE_WAY  = 3'b1 << FLAG_ONE_WAY;
    localparam logic [2:0] TILE_BACKDROP = 3'b1 << FLAG_BACKGROUND;

    typedef struct {
        logic               operation;
        logic [6:0]         tile_col;
        logic [5:0]         tile_row;
        logic [2:0]         tile_flags;
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
        logic signed [23:0] end_x;
        logic signed [23:0] end_y;
        logic               pass_up;
    } request_t;

    typedef struct {
        logic               hit;
        logic [16:0]        hit_t;
        logic signed [15:0] face_nx;
        logic signed [15:0] face_ny;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_wdata;

    grt_req_if req_ch ();
    grt_rsp_if rsp_ch ();

    grid_ray_traversal_hit #(
        .MAP_COLS   (MAP_COLS),
        .MAP_ROWS   (MAP_ROWS),
        .STEP_LIMIT (STEP_LIMIT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    logic [2:0] tile_map [0:MAP_COLS*MAP_ROWS-1];
    int unsigned cols_used;
    int unsigned rows_used;
    int unsigned tile_px;
    outcome_t    expected_q [$];
    int          errors;
    bit          idle_on;
    int          quiet_cycles;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b != 0) && (a < 0))
            q--;
        return q;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [2:0] flags_at(longint col, longint row);
        longint w;
        longint h;
        w = (cols_used < MAP_COLS) ? longint'(cols_used) : longint'(MAP_COLS);
        h = (rows_used < MAP_ROWS) ? longint'(rows_used) : longint'(MAP_ROWS);
        if (col < 0 || col >= w || row < 0 || row >= h)
            return FLAGS_OUTSIDE;
        return tile_map[row * MAP_COLS + col];
    endfunction

    function automatic bit is_blocking(logic [2:0] f, bit pass_up);
        return f[FLAG_SOLID] && !f[FLAG_BACKGROUND] && !(pass_up && f[FLAG_ONE_WAY]);
    endfunction

    function automatic longint unit_component(longint dc, longint unsigned mag);
        longint unsigned a;
        longint q;
        a = (dc < 0) ? -dc : dc;
        q = (a * 32767 + mag / 2) / mag;
        return (dc > 0) ? -q : q;
    endfunction

    function automatic outcome_t trace_ray(request_t it);
        outcome_t o;
        longint ax, ay, dx, dy, span, tx, ty, adx, ady, numx, numy, sx, sy;
        longint nx, ny, t;
        longint unsigned mag;
        bit pass_up, found, done, xfirst;
        o = '{1'b0, 17'd0, 16'sd0, 16'sd0};
        if (it.operation == OP_WRITE)
        begin
            if (it.tile_col < MAP_COLS && it.tile_row < MAP_ROWS)
                tile_map[it.tile_row * MAP_COLS + it.tile_col] = it.tile_flags;
            return o;
        end
        ax = longint'(it.start_x);
        ay = longint'(it.start_y);
        dx = longint'(it.end_x) - ax;
        dy = longint'(it.end_y) - ay;
        span = longint'((tile_px == 0) ? 1 : tile_px) * 256;
        pass_up = it.pass_up && (dy < 0);
        tx = floor_quot(ax, span);
        ty = floor_quot(ay, span);
        found = 0;
        t = 0;
        nx = 0;
        ny = 0;
        numx = 0;
        numy = 0;
        if (is_blocking(flags_at(tx, ty), pass_up))
        begin
            found = 1;
            if (dx == 0 && dy == 0)
                ny = -32767;
            else
            begin
                mag = root_floor(dx * dx + dy * dy);
                nx = unit_component(dx, mag);
                ny = unit_component(dy, mag);
            end
        end
        else
        begin
            sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
            sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            if (sx > 0)
                numx = (tx + 1) * span - ax;
            else if (sx < 0)
                numx = ax - tx * span;
            if (sy > 0)
                numy = (ty + 1) * span - ay;
            else if (sy < 0)
                numy = ay - ty * span;
            done = 0;
            for (int i = 0; i < STEP_LIMIT && !done; i++)
            begin
                xfirst = adx != 0 && (ady == 0 || numx * ady < numy * adx);
                if (xfirst)
                begin
                    tx += sx;
                    if (numx > adx)
                        done = 1;
                    else if (is_blocking(flags_at(tx, ty), pass_up))
                    begin
                        found = 1;
                        done = 1;
                        t = (numx * 65536 + adx / 2) / adx;
                        nx = -sx * 32767;
                    end
                    else
                        numx += span;
                end
                else
                begin
                    ty += sy;
                    if (ady == 0 || numy > ady)
                        done = 1;
                    else if (is_blocking(flags_at(tx, ty), pass_up))
                    begin
                        found = 1;
                        done = 1;
                        t = (numy * 65536 + ady / 2) / ady;
                        ny = -sy * 32767;
                    end
                    else
                        numy += span;
                end
            end
        end
        if (found)
        begin
            o.hit = 1'b1;
            o.hit_t = t[16:0];
            o.face_nx = nx[15:0];
            o.face_ny = ny[15:0];
        end
        return o;
    endfunction

    // ------------------------------------------------------------------
    // channel handling
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = expected_q.pop_front();
                if (rsp_ch.hit !== want.hit)
                    report_mismatch($sformatf("hit %0b, want %0b", rsp_ch.hit, want.hit));
                if (rsp_ch.hit_t !== want.hit_t)
                    report_mismatch($sformatf("hit_t %0d, want %0d",
                                              rsp_ch.hit_t, want.hit_t));
                if (rsp_ch.face_nx !== want.face_nx)
                    report_mismatch($sformatf("face_nx %0d, want %0d",
                                              rsp_ch.face_nx, want.face_nx));
                if (rsp_ch.face_ny !== want.face_ny)
                    report_mismatch($sformatf("face_ny %0d, want %0d",
                                              rsp_ch.face_ny, want.face_ny));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int hold;
        hold = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                if (idle_on && $urandom_range(0, 2) == 0)
                begin
                    rsp_ch.ready = 1'b0;
                    hold = $urandom_range(1, 12);
                end
                else
                begin
                    rsp_ch.ready = 1'b1;
                    hold = $urandom_range(1, 30);
                end
            end
            hold--;
        end
    end

    task automatic send_request(input request_t it);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.operation = it.operation;
        req_ch.tile_col = it.tile_col;
        req_ch.tile_row = it.tile_row;
        req_ch.tile_flags = it.tile_flags;
        req_ch.start_x = it.start_x;
        req_ch.start_y = it.start_y;
        req_ch.end_x = it.end_x;
        req_ch.end_y = it.end_y;
        req_ch.pass_one_way_upward = it.pass_up;
        req_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_q.push_back(trace_ray(it));
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IW-1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_GRID_WIDTH:  cols_used = 32'(value);
            REG_GRID_HEIGHT: rows_used = 32'(value[6:0]);
            REG_TILE_SIZE:   tile_px = 32'(value);
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [7:0] w, input logic [7:0] h, input logic [7:0] s);
        write_register(REG_GRID_WIDTH, w);
        write_register(REG_GRID_HEIGHT, h);
        write_register(REG_TILE_SIZE, s);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic request_t tile_write(int col, int row, logic [2:0] f);
        request_t it;
        it = '{OP_WRITE, col[6:0], row[5:0], f, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0};
        it.start_x = 24'($urandom);
        it.end_y = 24'($urandom);
        return it;
    endfunction

    function automatic request_t ray(longint x0, longint y0, longint x1, longint y1,
                                     bit pass_up);
        request_t it;
        it = '{OP_QUERY, 7'd0, 6'd0, 3'd0, x0[23:0], y0[23:0], x1[23:0], y1[23:0],
               pass_up};
        it.tile_col = 7'($urandom);
        it.tile_flags = 3'($urandom);
        return it;
    endfunction

    function automatic longint grid_coord(int tiles);
        longint s;
        s = (tile_px == 0) ? 1 : tile_px;
        return ($urandom_range(0, (tiles + 2) * s) - s) * 256 + $urandom_range(0, 255);
    endfunction

    function automatic request_t random_request();
        int w;
        int h;
        longint x0, y0, x1, y1;
        w = (cols_used < MAP_COLS) ? cols_used : MAP_COLS;
        h = (rows_used < MAP_ROWS) ? rows_used : MAP_ROWS;
        if ($urandom_range(0, 9) < 4)
        begin
            if ($urandom_range(0, 7) == 0)
                return tile_write($urandom_range(0, 127), $urandom_range(0, 63),
                                  3'($urandom));
            return tile_write($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                              ($urandom_range(0, 2) == 0) ? 3'd0 : 3'($urandom));
        end
        if ($urandom_range(0, 19) == 0)
            return ray($signed(24'($urandom)), $signed(24'($urandom)),
                       $signed(24'($urandom)), $signed(24'($urandom)), 1'($urandom));
        x0 = grid_coord(w);
        y0 = grid_coord(h);
        case ($urandom_range(0, 5))
            0: begin x1 = x0; y1 = grid_coord(h); end
            1: begin x1 = grid_coord(w); y1 = y0; end
            2: begin x1 = x0; y1 = y0; end
            default: begin x1 = grid_coord(w); y1 = grid_coord(h); end
        endcase
        return ray(x0, y0, x1, y1, 1'($urandom));
    endfunction

    task automatic test_directed();
        // defaults: 100 x 40 tiles of 32 px, 8192 raw units per tile
        send_request(tile_write(127, 63, 3'h7));
        send_request(tile_write(0, 0, 3'h0));
        send_request(tile_write(5, 5, TILE_WALL));
        send_request(ray(164 * 256, 164 * 256, 164 * 256, 164 * 256, 1'b0));
        send_request(ray(164 * 256, 164 * 256, 300 * 256 + 17, 100 * 256, 1'b0));
        send_request(tile_write(12, 5, TILE_WALL));
        send_request(ray(240 * 256, 176 * 256, 500 * 256, 176 * 256, 1'b0));
        send_request(tile_write(7, 8, TILE_WALL | TILE_ONE_WAY));
        send_request(ray(240 * 256, 340 * 256, 240 * 256, 200 * 256, 1'b1));
        send_request(ray(240 * 256, 340 * 256, 240 * 256, 200 * 256, 1'b0));
        send_request(ray(240 * 256, 200 * 256, 240 * 256, 340 * 256, 1'b1));
        send_request(tile_write(7, 12, TILE_WALL | TILE_BACKDROP));
        send_request(ray(240 * 256, 370 * 256, 240 * 256, 450 * 256, 1'b0));
        send_request(tile_write(21, 20, TILE_WALL));
        send_request(tile_write(20, 21, TILE_WALL));
        send_request(ray(656 * 256, 656 * 256, 720 * 256, 720 * 256, 1'b0));
        send_request(tile_write(31, 30, TILE_WALL));
        send_request(ray(976 * 256, 976 * 256, 992 * 256, 976 * 256, 1'b0));
        send_request(ray(-8388608, 100, 8388607, 100, 1'b0));
        send_request(ray(8388607, 8388607, -8388608, -8388608, 1'b1));
        send_request(ray(50 * 256, 50 * 256, 50 * 256, -8388608, 1'b0));
        send_request(ray(2000 * 256 + 1, 900 * 256, 2000 * 256 + 1, 1000 * 256, 1'b0));
        drain_results();
    endtask

    task automatic test_grid_settings();
        logic [7:0] settings [6][3] = '{
            '{8'd128, 8'd64, 8'd255}, '{8'd1, 8'd1, 8'd1}, '{8'd255, 8'd127, 8'd0},
            '{8'd8, 8'd4, 8'd3}, '{8'd0, 8'd0, 8'd9}, '{8'd100, 8'd40, 8'd32}};
        for (int p = 0; p < 6; p++)
        begin
            set_grid(settings[p][0], settings[p][1], settings[p][2]);
            repeat (90) send_request(random_request());
            drain_results();
        end
    endtask

    task automatic test_dense_map();
        set_grid(8'd40, 8'd20, 8'd5);
        for (int k = 0; k < 60; k++)
            send_request(tile_write($urandom_range(0, 39), $urandom_range(0, 19),
                                    TILE_WALL | 3'($urandom_range(0, 3) << 1)));
        repeat (60) send_request(random_request());
        drain_results();
    endtask

    task automatic test_back_to_back();
        idle_on = 0;
        repeat (100) send_request(random_request());
        drain_results();
    endtask

    initial
    begin
        errors = 0;
        quiet_cycles = 0;
        idle_on = 1;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_GRID_WIDTH;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_WRITE;
        req_ch.tile_col = '0;
        req_ch.tile_row = '0;
        req_ch.tile_flags = '0;
        req_ch.start_x = '0;
        req_ch.start_y = '0;
        req_ch.end_x = '0;
        req_ch.end_y = '0;
        req_ch.pass_one_way_upward = 1'b0;
        for (int k = 0; k < MAP_COLS * MAP_ROWS; k++)
            tile_map[k] = 3'd0;
        cols_used = 32'(GRID_WIDTH_RST);
        rows_used = 32'(GRID_HEIGHT_RST);
        tile_px = 32'(TILE_SIZE_RST);
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_grid_settings();
        test_dense_map();
        test_back_to_back();

        repeat (20) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
